>>> rtl/direct_mapped_write_back_cache_assert.svh
// assertion macros shared by the cache checker
// no dependencies
`ifndef DIRECT_MAPPED_WRITE_BACK_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_WRITE_BACK_CACHE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DMWBC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define DMWBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dmwbc_pkg.sv
// shared types and constants of the direct-mapped write-back cache
// no dependencies
`default_nettype none

package dmwbc_pkg;

  localparam int ADDR_W       = 16;
  localparam int DATA_W       = 32;
  localparam int COST_W       = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int WORD_BYTES   = 4;
  localparam int NUM_LINES    = 256;
  localparam int LINE_BYTES   = 64;
  localparam int MEMORY_BYTES = 65536;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_e;

  typedef enum logic [1:0] {
    REG_MEM_RD   = 2'd0,
    REG_MEM_WR   = 2'd1,
    REG_CACHE_RD = 2'd2,
    REG_CACHE_WR = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    COST_MEM_RD,
    COST_MEM_WR,
    COST_CACHE_RD,
    COST_CACHE_WR
  } cost_sel_e;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOK,
    ST_CHECK,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic      sweep;
    logic      latch;
    logic      check;
    logic      set_wb;
    logic      wb_move;
    logic      fill_move;
    logic      move_rst;
    logic      cost_en;
    cost_sel_e cost_sel;
    logic      time_clr;
    logic      tag_wr;
    logic      word_rd;
    logic      word_wr;
    logic      out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic       sweep_done;
    logic [1:0] command;
    logic       addr_err;
    logic       is_hit;
    logic       victim_dirty;
    logic       move_last;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/dmwbc_ctrl.sv
// controller state machine of the cache: sequences lookup, write-back, fill, access
// depends on dmwbc_pkg
`default_nettype none

module dmwbc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire dmwbc_pkg::sts_t  sts_i,
  output dmwbc_pkg::ctl_t       ctl_o
);

  dmwbc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmwbc_pkg::ST_SWEEP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == dmwbc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      dmwbc_pkg::ST_SWEEP: begin
        ctl_o.sweep = 1'b1;
        if (sts_i.sweep_done) begin
          ctl_o.sweep = 1'b0;
          state_d     = dmwbc_pkg::ST_IDLE;
        end
      end
      dmwbc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          state_d     = dmwbc_pkg::ST_LOOK;
        end
      end
      dmwbc_pkg::ST_LOOK: begin
        state_d = dmwbc_pkg::ST_CHECK;
      end
      dmwbc_pkg::ST_CHECK: begin
        ctl_o.check = 1'b1;
        state_d     = dmwbc_pkg::ST_DONE;
        case (sts_i.command)
          dmwbc_pkg::CMD_CLEAR: ctl_o.time_clr = 1'b1;
          dmwbc_pkg::CMD_NOP:   ctl_o.time_clr = 1'b0;
          default: begin
            if (!sts_i.addr_err) begin
              if (sts_i.is_hit) begin
                state_d = dmwbc_pkg::ST_ACCESS;
              end else if (sts_i.victim_dirty) begin
                ctl_o.set_wb   = 1'b1;
                ctl_o.move_rst = 1'b1;
                ctl_o.cost_en  = 1'b1;
                ctl_o.cost_sel = dmwbc_pkg::COST_MEM_WR;
                state_d        = dmwbc_pkg::ST_WB;
              end else begin
                ctl_o.move_rst = 1'b1;
                ctl_o.cost_en  = 1'b1;
                ctl_o.cost_sel = dmwbc_pkg::COST_MEM_RD;
                state_d        = dmwbc_pkg::ST_FILL;
              end
            end
          end
        endcase
      end
      dmwbc_pkg::ST_WB: begin
        ctl_o.wb_move = 1'b1;
        if (sts_i.move_last) begin
          ctl_o.move_rst = 1'b1;
          ctl_o.cost_en  = 1'b1;
          ctl_o.cost_sel = dmwbc_pkg::COST_MEM_RD;
          state_d        = dmwbc_pkg::ST_FILL;
        end
      end
      dmwbc_pkg::ST_FILL: begin
        ctl_o.fill_move = 1'b1;
        if (sts_i.move_last) begin
          ctl_o.tag_wr = 1'b1;
          state_d      = dmwbc_pkg::ST_ACCESS;
        end
      end
      dmwbc_pkg::ST_ACCESS: begin
        ctl_o.cost_en = 1'b1;
        if (sts_i.command == dmwbc_pkg::CMD_READ) begin
          ctl_o.word_rd  = 1'b1;
          ctl_o.cost_sel = dmwbc_pkg::COST_CACHE_RD;
        end else begin
          ctl_o.word_wr  = 1'b1;
          ctl_o.cost_sel = dmwbc_pkg::COST_CACHE_WR;
        end
        state_d = dmwbc_pkg::ST_DONE;
      end
      dmwbc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = dmwbc_pkg::ST_IDLE;
        end
      end
      default: state_d = dmwbc_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dmwbc_dpath.sv
// datapath of the cache: tag, word and backing memories, cost counter, result registers
// depends on dmwbc_pkg
`default_nettype none

module dmwbc_dpath #(
  parameter int NUM_LINES    = dmwbc_pkg::NUM_LINES,
  parameter int LINE_BYTES   = dmwbc_pkg::LINE_BYTES,
  parameter int MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire dmwbc_pkg::ctl_t                  ctl_i,
  output dmwbc_pkg::sts_t                       sts_o,
  input  wire logic [1:0]                       command_i,
  input  wire logic [dmwbc_pkg::ADDR_W-1:0]     address_i,
  input  wire logic [dmwbc_pkg::DATA_W-1:0]     write_word_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [dmwbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dmwbc_pkg::COST_W-1:0]     cfg_data_i,
  output logic [dmwbc_pkg::DATA_W-1:0]          read_word_o,
  output logic                                  hit_o,
  output logic                                  wrote_back_o,
  output logic                                  address_error_o,
  output logic [dmwbc_pkg::DATA_W-1:0]          elapsed_cost_o
);

  localparam int WPL       = LINE_BYTES / dmwbc_pkg::WORD_BYTES;
  localparam int MEM_WORDS = MEMORY_BYTES / dmwbc_pkg::WORD_BYTES;
  localparam int OFF_W     = $clog2(LINE_BYTES);
  localparam int WSEL_W    = $clog2(WPL);
  localparam int IDX_W     = $clog2(NUM_LINES);
  localparam int SPAN_W    = OFF_W + IDX_W;
  localparam int TAG_W     = (dmwbc_pkg::ADDR_W > SPAN_W) ? dmwbc_pkg::ADDR_W - SPAN_W : 1;
  localparam int CW_W      = IDX_W + WSEL_W;
  localparam int MW_W      = $clog2(MEM_WORDS);
  localparam int CNT_W     = WSEL_W + 1;

  // latched request
  logic [1:0]                   cmd_q;
  logic [dmwbc_pkg::ADDR_W-1:0] addr_q;
  logic [dmwbc_pkg::DATA_W-1:0] wdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q   <= command_i;
      addr_q  <= address_i;
      wdata_q <= write_word_i;
    end
  end

  // address fields
  logic [IDX_W-1:0]  line;
  logic [TAG_W-1:0]  tag;
  logic [WSEL_W-1:0] wsel;
  logic [31:0]       base_byte;
  logic              addr_err;

  assign line      = IDX_W'(32'(addr_q) >> OFF_W);
  assign tag       = TAG_W'(32'(addr_q) >> SPAN_W);
  assign wsel      = addr_q[2 +: WSEL_W];
  assign base_byte = (32'(addr_q) >> OFF_W) << OFF_W;
  assign addr_err  = (base_byte + 32'(LINE_BYTES)) > 32'(MEMORY_BYTES);

  // configuration registers
  logic [dmwbc_pkg::COST_W-1:0] mem_rd_cost_q, mem_wr_cost_q, cache_rd_cost_q, cache_wr_cost_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_rd_cost_q   <= dmwbc_pkg::COST_W'(100);
      mem_wr_cost_q   <= dmwbc_pkg::COST_W'(50);
      cache_rd_cost_q <= dmwbc_pkg::COST_W'(1);
      cache_wr_cost_q <= dmwbc_pkg::COST_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dmwbc_pkg::REG_MEM_RD:   mem_rd_cost_q   <= cfg_data_i;
        dmwbc_pkg::REG_MEM_WR:   mem_wr_cost_q   <= cfg_data_i;
        dmwbc_pkg::REG_CACHE_RD: cache_rd_cost_q <= cfg_data_i;
        dmwbc_pkg::REG_CACHE_WR: cache_wr_cost_q <= cfg_data_i;
        default:                 mem_rd_cost_q   <= mem_rd_cost_q;
      endcase
    end
  end

  // cost counter
  logic [dmwbc_pkg::COST_W-1:0] cost;
  logic [dmwbc_pkg::DATA_W-1:0] time_q;

  always_comb begin
    case (ctl_i.cost_sel)
      dmwbc_pkg::COST_MEM_RD:   cost = mem_rd_cost_q;
      dmwbc_pkg::COST_MEM_WR:   cost = mem_wr_cost_q;
      dmwbc_pkg::COST_CACHE_RD: cost = cache_rd_cost_q;
      dmwbc_pkg::COST_CACHE_WR: cost = cache_wr_cost_q;
      default:                  cost = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0;
    end else if (ctl_i.time_clr) begin
      time_q <= '0;
    end else if (ctl_i.cost_en) begin
      time_q <= time_q + dmwbc_pkg::DATA_W'(cost);
    end
  end

  // line move counter, one word a cycle; the registered read data is written with the previous count
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_m1;
  logic              move_last;

  assign move_last = (cnt_q == CNT_W'(WPL));
  assign cnt_m1    = cnt_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.move_rst) begin
      cnt_q <= '0;
    end else if (ctl_i.wb_move || ctl_i.fill_move) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // backing clear sweep after reset
  logic [MW_W:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctl_i.sweep) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // line state: valid and dirty flags, tag memory
  logic [NUM_LINES-1:0] valid_q, dirty_q;
  logic [TAG_W-1:0]     tag_mem [NUM_LINES];
  logic [TAG_W-1:0]     tag_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
    end else if (ctl_i.tag_wr) begin
      valid_q[line] <= 1'b1;
      dirty_q[line] <= 1'b0;
    end else if (ctl_i.word_wr) begin
      dirty_q[line] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.tag_wr) begin
      tag_mem[line] <= tag;
    end
    tag_rd_q <= tag_mem[line];
  end

  // memory storage and port signals
  logic [dmwbc_pkg::DATA_W-1:0] cache_mem [NUM_LINES * WPL];
  logic [dmwbc_pkg::DATA_W-1:0] cache_rd_q, cache_wd;
  logic [CW_W-1:0]              cache_wa, cache_ra;
  logic                         cache_we, cache_re;
  logic [dmwbc_pkg::DATA_W-1:0] backing_mem [MEM_WORDS];
  logic [dmwbc_pkg::DATA_W-1:0] backing_rd_q, backing_wd;
  logic [MW_W-1:0]              backing_wa, backing_ra;
  logic                         backing_we, backing_re;

  // cache word memory
  always_comb begin
    cache_we = 1'b0;
    cache_wa = {line, wsel};
    cache_wd = wdata_q;
    if (ctl_i.fill_move && (cnt_q != '0)) begin
      cache_we = 1'b1;
      cache_wa = {line, cnt_m1[WSEL_W-1:0]};
      cache_wd = backing_rd_q;
    end else if (ctl_i.word_wr) begin
      cache_we = 1'b1;
    end
    cache_re = ctl_i.word_rd || (ctl_i.wb_move && !move_last);
    cache_ra = ctl_i.wb_move ? {line, cnt_q[WSEL_W-1:0]} : {line, wsel};
  end

  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      cache_mem[cache_wa] <= cache_wd;
    end
    if (cache_re) begin
      cache_rd_q <= cache_mem[cache_ra];
    end
  end

  // backing memory
  always_comb begin
    backing_we = 1'b0;
    backing_wa = clr_q[MW_W-1:0];
    backing_wd = '0;
    if (ctl_i.sweep) begin
      backing_we = 1'b1;
    end else if (ctl_i.wb_move && (cnt_q != '0)) begin
      backing_we = 1'b1;
      backing_wa = MW_W'(32'({tag_rd_q, line, cnt_m1[WSEL_W-1:0]}));
      backing_wd = cache_rd_q;
    end
    backing_re = ctl_i.fill_move && !move_last;
    backing_ra = MW_W'(((32'(addr_q) >> OFF_W) << WSEL_W) | 32'(cnt_q[WSEL_W-1:0]));
  end

  always_ff @(posedge clk_i) begin
    if (backing_we) begin
      backing_mem[backing_wa] <= backing_wd;
    end
    if (backing_re) begin
      backing_rd_q <= backing_mem[backing_ra];
    end
  end

  // status
  logic access_cmd;

  assign access_cmd          = (cmd_q == dmwbc_pkg::CMD_READ) || (cmd_q == dmwbc_pkg::CMD_WRITE);
  assign sts_o.sweep_done    = (clr_q == (MW_W + 1)'(MEM_WORDS));
  assign sts_o.command       = cmd_q;
  assign sts_o.addr_err      = addr_err;
  assign sts_o.is_hit        = valid_q[line] && (tag_rd_q == tag);
  assign sts_o.victim_dirty  = valid_q[line] && dirty_q[line];
  assign sts_o.move_last     = move_last;

  // per-access flags
  logic hit_q, wb_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.check) begin
      hit_q <= access_cmd && !addr_err && sts_o.is_hit;
      wb_q  <= ctl_i.set_wb;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      read_word_o     <= (cmd_q == dmwbc_pkg::CMD_READ && !addr_err) ? cache_rd_q : '0;
      hit_o           <= hit_q;
      wrote_back_o    <= wb_q;
      address_error_o <= access_cmd && addr_err;
      elapsed_cost_o  <= time_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/direct_mapped_write_back_cache.sv
// Direct-mapped write-allocate write-back cache with its own backing memory. One item
// is taken at a time. A hit goes through transfer, tag read, compare, access and result
// load; a clear, a no-op or an address error skips the access; a clean miss adds a fill
// of the line before the access and a dirty miss adds a write-back of the victim before
// the fill, both moving one word a cycle through the word and backing memories. After
// reset the backing memory is cleared one word a cycle, with in_ready_o low;
// configuration writes are taken at any time. The result sits in an output register, so
// the next item is taken while it waits. Depends on dmwbc_pkg, dmwbc_ctrl, dmwbc_dpath.
`default_nettype none

module direct_mapped_write_back_cache #(
  parameter int NUM_LINES    = dmwbc_pkg::NUM_LINES,
  parameter int LINE_BYTES   = dmwbc_pkg::LINE_BYTES,
  parameter int MEMORY_BYTES = dmwbc_pkg::MEMORY_BYTES
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [1:0]                       command_i,
  input  wire logic [dmwbc_pkg::ADDR_W-1:0]     address_i,
  input  wire logic [dmwbc_pkg::DATA_W-1:0]     write_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [dmwbc_pkg::DATA_W-1:0]          read_word_o,
  output logic                                  hit_o,
  output logic                                  wrote_back_o,
  output logic                                  address_error_o,
  output logic [dmwbc_pkg::DATA_W-1:0]          elapsed_cost_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [dmwbc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [dmwbc_pkg::COST_W-1:0]     cfg_data_i
);

  dmwbc_pkg::ctl_t ctl;
  dmwbc_pkg::sts_t sts;

  // sequencer
  dmwbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // storage and arithmetic
  dmwbc_dpath #(
    .NUM_LINES    (NUM_LINES),
    .LINE_BYTES   (LINE_BYTES),
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .command_i       (command_i),
    .address_i       (address_i),
    .write_word_i    (write_word_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .read_word_o     (read_word_o),
    .hit_o           (hit_o),
    .wrote_back_o    (wrote_back_o),
    .address_error_o (address_error_o),
    .elapsed_cost_o  (elapsed_cost_o)
  );

endmodule

`default_nettype wire

>>> rtl/dmwbc_checker.sv
// port-level checks of the cache, bound to the top level
// depends on dmwbc_pkg and direct_mapped_write_back_cache_assert.svh
`default_nettype none
`include "direct_mapped_write_back_cache_assert.svh"

module dmwbc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic [dmwbc_pkg::DATA_W-1:0]  read_word_o,
  input wire logic                          hit_o,
  input wire logic                          wrote_back_o,
  input wire logic                          address_error_o
);

  // result held until its transfer
  `DMWBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped before transfer")

  // one item at a time: no new transfer right after one
  `DMWBC_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "input taken while busy")

  // an ignored access reports nothing else
  `DMWBC_ASSERT_IMPL(a_err_quiet, clk_i, rst_ni, out_valid_o && address_error_o, !hit_o && !wrote_back_o && (read_word_o == '0), "error result with access flags")

  // a write-back only happens on a miss
  `DMWBC_ASSERT_IMPL(a_wb_miss, clk_i, rst_ni, out_valid_o && wrote_back_o, !hit_o, "write-back reported on a hit")

endmodule

bind direct_mapped_write_back_cache dmwbc_checker u_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
// self-checking bench for the direct-mapped write-back cache: random and directed accesses
// with a behavioral cache and backing memory as predictor; depends on dmwbc_pkg and the rtl
`default_nettype none

module tb_top;

  localparam int WPL       = dmwbc_pkg::LINE_BYTES / dmwbc_pkg::WORD_BYTES;
  localparam int MEM_WORDS = dmwbc_pkg::MEMORY_BYTES / dmwbc_pkg::WORD_BYTES;
  localparam int SPAN      = dmwbc_pkg::NUM_LINES * dmwbc_pkg::LINE_BYTES;
  localparam int IDLE_LIM  = 100000;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [31:0] write_word;
  } access_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic        hit;
    logic        wrote_back;
    logic        address_error;
    logic [31:0] elapsed_cost;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] command_i = '0;
  logic [15:0] address_i = '0;
  logic [31:0] write_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] read_word_o, elapsed_cost_o;
  logic hit_o, wrote_back_o, address_error_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  direct_mapped_write_back_cache u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] cost_q [4];
  logic        pv_valid [dmwbc_pkg::NUM_LINES];
  logic        pv_dirty [dmwbc_pkg::NUM_LINES];
  logic [1:0]  pv_tag [dmwbc_pkg::NUM_LINES];
  logic [31:0] pv_words [dmwbc_pkg::NUM_LINES*WPL];
  logic [31:0] pv_mem [MEM_WORDS];
  logic [31:0] pv_time;

  access_t  pending_q [$];
  outcome_t expected_q [$];
  int errors = 0, accepted = 0, checked = 0, hits = 0, wbs = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;
  bit in_taken = 0;
  bit stim_done = 0;

  function automatic outcome_t predict_access(access_t a);
    outcome_t r;
    logic [15:0] addr;
    int line, tg, ci, base;
    r = '0;
    addr = {a.address[15:2], 2'b00};
    if (a.command == dmwbc_pkg::CMD_CLEAR) begin
      pv_time = '0;
    end else if (a.command == dmwbc_pkg::CMD_READ || a.command == dmwbc_pkg::CMD_WRITE) begin
      base = addr - (addr % dmwbc_pkg::LINE_BYTES);
      if (base + dmwbc_pkg::LINE_BYTES > dmwbc_pkg::MEMORY_BYTES) begin
        r.address_error = 1'b1;
      end else begin
        line = (addr / dmwbc_pkg::LINE_BYTES) % dmwbc_pkg::NUM_LINES;
        tg   = addr / SPAN;
        ci   = line * WPL + (addr % dmwbc_pkg::LINE_BYTES) / dmwbc_pkg::WORD_BYTES;
        if (pv_valid[line] && pv_tag[line] == tg) begin
          r.hit = 1'b1;
        end else begin
          // write back the victim at its own address
          if (pv_valid[line] && pv_dirty[line]) begin
            for (int w = 0; w < WPL; w++)
              pv_mem[(pv_tag[line]*SPAN + line*dmwbc_pkg::LINE_BYTES)/dmwbc_pkg::WORD_BYTES
                     + w] = pv_words[line*WPL + w];
            pv_time += cost_q[dmwbc_pkg::REG_MEM_WR];
            r.wrote_back = 1'b1;
          end
          for (int w = 0; w < WPL; w++)
            pv_words[line*WPL + w] = pv_mem[base/dmwbc_pkg::WORD_BYTES + w];
          pv_time += cost_q[dmwbc_pkg::REG_MEM_RD];
          pv_valid[line] = 1'b1;
          pv_tag[line]   = tg[1:0];
          pv_dirty[line] = 1'b0;
        end
        if (a.command == dmwbc_pkg::CMD_READ) begin
          r.read_word = pv_words[ci];
          pv_time += cost_q[dmwbc_pkg::REG_CACHE_RD];
        end else begin
          pv_words[ci] = a.write_word;
          pv_time += cost_q[dmwbc_pkg::REG_CACHE_WR];
          pv_dirty[line] = 1'b1;
        end
      end
    end
    r.elapsed_cost = pv_time;
    return r;
  endfunction

  // driver: offers queued items, idles at random, holds an item until its transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pending_q.size() > 0 &&
            !(send_idle > 0 && $urandom_range(99, 0) < send_idle)) begin
          in_valid_i   <= 1'b1;
          command_i    <= pending_q[0].command;
          address_i    <= pending_q[0].address;
          write_word_i <= pending_q[0].write_word;
          pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: long hold when asked, otherwise random idling
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles <= hold_cycles - 1;
      end else begin
        out_ready_i <= !(recv_idle > 0 && $urandom_range(99, 0) < recv_idle);
      end
    end
  end

  // monitor: predicts on input transfer, checks on output transfer
  always @(posedge clk_i) begin
    access_t a;
    outcome_t e;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        a = '{command_i, address_i, write_word_i};
        expected_q.push_back(predict_access(a));
        accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no pending expectation");
          errors++;
        end else begin
          e = expected_q.pop_front();
          checked++;
          if (hit_o) hits++;
          if (wrote_back_o) wbs++;
          if (read_word_o !== e.read_word) begin
            $error("read_word exp %h got %h", e.read_word, read_word_o); errors++;
          end
          if (hit_o !== e.hit) begin
            $error("hit exp %b got %b", e.hit, hit_o); errors++;
          end
          if (wrote_back_o !== e.wrote_back) begin
            $error("wrote_back exp %b got %b", e.wrote_back, wrote_back_o); errors++;
          end
          if (address_error_o !== e.address_error) begin
            $error("address_error exp %b got %b", e.address_error, address_error_o);
            errors++;
          end
          if (elapsed_cost_o !== e.elapsed_cost) begin
            $error("elapsed_cost exp %h got %h", e.elapsed_cost, elapsed_cost_o); errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int stall_count = 0;
  always @(posedge clk_i) begin
    if (rst_ni && !stim_done) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= IDLE_LIM) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic access_t make_access(logic [1:0] c, logic [15:0] ad, logic [31:0] d);
    access_t a;
    a.command = c; a.address = ad; a.write_word = d;
    return a;
  endfunction

  // mostly addresses that collide in a few lines so hits, misses and write-backs all occur
  function automatic access_t rand_access();
    logic [15:0] ad;
    int k;
    k = $urandom_range(99, 0);
    if (k < 70)
      ad = {2'($urandom_range(3, 0)), 8'($urandom_range(7, 0)), 6'($urandom)};
    else
      ad = 16'($urandom);
    k = $urandom_range(99, 0);
    return make_access(k < 45 ? dmwbc_pkg::CMD_READ :
                       k < 90 ? dmwbc_pkg::CMD_WRITE :
                       k < 95 ? dmwbc_pkg::CMD_CLEAR : dmwbc_pkg::CMD_NOP,
                       ad, $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_cost(dmwbc_pkg::reg_idx_e idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cost_q[idx] = v;
  endtask

  initial begin
    cost_q[dmwbc_pkg::REG_MEM_RD] = 100; cost_q[dmwbc_pkg::REG_MEM_WR] = 50;
    cost_q[dmwbc_pkg::REG_CACHE_RD] = 1; cost_q[dmwbc_pkg::REG_CACHE_WR] = 1;
    for (int i = 0; i < dmwbc_pkg::NUM_LINES; i++) begin
      pv_valid[i] = 0; pv_dirty[i] = 0; pv_tag[i] = 0;
    end
    for (int i = 0; i < dmwbc_pkg::NUM_LINES*WPL; i++) pv_words[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) pv_mem[i] = '0;
    pv_time = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: extremes, each command, victim write-back, nop and clear
    pending_q.push_back(make_access(dmwbc_pkg::CMD_READ,  16'h0000, '0));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_WRITE, 16'h0003, 32'hFFFF_FFFF));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_READ,  16'h0000, '0));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_WRITE, 16'h4000, 32'hA5A5_5A5A));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_READ,  16'h0000, '0));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_READ,  16'h4000, '0));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_WRITE, 16'hFFFF, 32'h1234_5678));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_READ,  16'hFFFC, '0));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_NOP,   16'hFFFF, 32'hFFFF_FFFF));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_CLEAR, 16'h0000, '0));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_WRITE, 16'hC03C, 32'h0000_0001));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_READ,  16'h003C, '0));
    pending_q.push_back(make_access(dmwbc_pkg::CMD_READ,  16'hC03C, '0));
    wait_drained();

    // sender idles lightly, receiver heavily, with one long receiver hold
    send_idle = 16; recv_idle = 65;
    for (int i = 0; i < 380; i++) pending_q.push_back(rand_access());
    hold_cycles = 600;
    wait_drained();

    write_cost(dmwbc_pkg::REG_MEM_RD, 16'hFFFF); write_cost(dmwbc_pkg::REG_MEM_WR, 16'hFFFF);
    write_cost(dmwbc_pkg::REG_CACHE_RD, 16'hFFFF);
    write_cost(dmwbc_pkg::REG_CACHE_WR, 16'hFFFF);
    send_idle = 65; recv_idle = 16;
    for (int i = 0; i < 380; i++) pending_q.push_back(rand_access());
    wait_drained();

    write_cost(dmwbc_pkg::REG_MEM_RD, 16'h0000); write_cost(dmwbc_pkg::REG_MEM_WR, 16'h0000);
    write_cost(dmwbc_pkg::REG_CACHE_RD, 16'h0000);
    write_cost(dmwbc_pkg::REG_CACHE_WR, 16'h0000);
    send_idle = 0; recv_idle = 0;
    for (int i = 0; i < 190; i++) pending_q.push_back(rand_access());
    wait_drained();

    // sender waits until everything is back, then a last burst
    write_cost(dmwbc_pkg::REG_MEM_RD, 16'($urandom));
    write_cost(dmwbc_pkg::REG_CACHE_WR, 16'($urandom));
    for (int i = 0; i < 190; i++) pending_q.push_back(rand_access());
    wait_drained();

    stim_done = 1;
    $display("checked %0d results of %0d transfers, %0d hits, %0d write-backs",
             checked, accepted, hits, wbs);
    if (errors == 0 && expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
